@@ design/trle_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// trle_pkg : shared types and constants of the tolerant run-length encoder
// Holds field widths, register indexes, reset values and the run-entry type.
// ============================================================================
package trle_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int TIME_W    = 32;
    localparam int MAXRUNS_W = 5;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 32;
    localparam int REM_STEPS = SAMPLE_W;
    localparam int STEP_W    = $clog2(REM_STEPS);

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_INTERVAL   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RELATIVE   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_RUNS   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_ALIVE_TIME = 2'd3;

    // register reset values
    localparam logic [SAMPLE_W-1:0]  RST_INTERVAL   = 16'd1;
    localparam logic [MAXRUNS_W-1:0] RST_MAX_RUNS   = 5'd16;
    localparam logic [TIME_W-1:0]    RST_ALIVE_TIME = 32'hFFFF_FFFF;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // one stored run; value sits in the low half
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] value;
    } t_run_entry;

    // status of the iterative remainder unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

@@ design/tolerant_run_length_encoder_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tolerant_run_length_encoder_core : lossy run-length encoder, top level
// Groups slow sensor samples into runs and flushes them on age or on count.
// ============================================================================
// One input word carries a sample and a millisecond timestamp; the block
// accepts one word at a time and is ready again once that word is done.
// A word that causes no flush passes through the remainder unit in bucket mode
// (one quotient bit a cycle) and skips it in relative mode. A flush reads the
// stored runs one by one through the single read port of the run store, or
// emits a single zero pair for an empty store, and it holds whenever the
// output side stalls. Results leave through an
// output register, so a new word may be taken while the last result waits.
// The run store needs no clearing pass: only entries below the run total
// are ever read. Configuration writes land at once and belong in idle time.
// ============================================================================
module tolerant_run_length_encoder_core #(
    parameter int RUN_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side; tdata: sample [15:0], now_ms [47:16]
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [47:0]                   i_s_tdata,
    // master side; tdata: run_value [15:0], run_count [31:16]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,
    output logic                          o_m_tlast,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [trle_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [trle_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import trle_pkg::*;

    localparam int AW = $clog2(RUN_DEPTH);
    localparam int TW = $clog2(RUN_DEPTH + 1);
    localparam int CW = (TW > MAXRUNS_W) ? TW : MAXRUNS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_FLUSH_RD = 3'd2;
    localparam logic [2:0] S_FLUSH_WR = 3'd3;
    localparam logic [2:0] S_PREP     = 3'd4;
    localparam logic [2:0] S_DIV      = 3'd5;
    localparam logic [2:0] S_JOIN     = 3'd6;
    localparam logic [2:0] S_UPD      = 3'd7;

    // configuration registers
    logic [SAMPLE_W-1:0]  r_interval;
    logic                 r_relative;
    logic [MAXRUNS_W-1:0] r_max_runs;
    logic [TIME_W-1:0]    r_alive;

    // control state
    logic [2:0]           r_state;
    logic [TW-1:0]        r_total;
    logic [TIME_W-1:0]    r_flush_time;
    logic [AW-1:0]        r_k;
    logic                 r_post;
    logic                 r_join;

    // item payload
    logic [SAMPLE_W-1:0]  r_sample;
    logic [TIME_W-1:0]    r_now;

    // output register
    logic                 r_out_valid;
    t_run_entry           r_out_data;
    logic                 r_out_last;

    // store and remainder unit
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    t_run_entry           w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    t_run_entry           w_rdata;
    logic                 w_rem_start;
    logic [SAMPLE_W-1:0]  w_rem;
    t_rem_stat            w_rem_stat;

    // combinational helpers
    logic                 w_slot_free;
    logic                 w_out_load;
    logic [TIME_W-1:0]    w_elapsed;
    logic [SAMPLE_W-1:0]  w_iv_eff;
    logic [CW-1:0]        w_lim;
    logic [SAMPLE_W:0]    w_rel_hi;
    logic [SAMPLE_W:0]    w_rel_lo_s;
    logic [SAMPLE_W-1:0]  w_bkt_lo;
    logic [SAMPLE_W:0]    w_bkt_hi;
    logic                 w_join;
    logic [TW-1:0]        w_last_idx;
    logic                 w_fl_last;
    logic [TW-1:0]        w_new_total;

    trle_store #(
        .DEPTH (RUN_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    trle_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_sample),
        .i_divisor  (w_iv_eff),
        .o_rem      (w_rem),
        .o_stat     (w_rem_stat)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tlast   = r_out_last;
    assign w_slot_free = !r_out_valid || i_m_tready;

    // a new result enters the output register this cycle
    assign w_out_load  = w_slot_free &&
                         (((r_state == S_FLUSH_RD) && (r_total == '0)) ||
                          (r_state == S_FLUSH_WR));

    // effective run limit: max_runs clamped to 1..RUN_DEPTH
    always_comb begin
        if (r_max_runs == '0) begin
            w_lim = CW'(1);
        end else if (CW'(r_max_runs) > CW'(RUN_DEPTH)) begin
            w_lim = CW'(RUN_DEPTH);
        end else begin
            w_lim = CW'(r_max_runs);
        end
    end

    assign w_elapsed  = r_now - r_flush_time;
    assign w_iv_eff   = (r_interval == '0) ? SAMPLE_W'(1) : r_interval;
    assign w_last_idx = r_total - TW'(1);

    // run membership: the last run's value is in w_rdata. In bucket mode
    // sample - rem is the bucket base, so the run joins when its value lies
    // in [base, base + interval - 1]; this avoids a second division.
    always_comb begin
        w_rel_hi   = {1'b0, w_rdata.value} + {1'b0, r_interval};
        w_rel_lo_s = {1'b0, r_sample} + {1'b0, r_interval};
        w_bkt_lo   = r_sample - w_rem;
        w_bkt_hi   = {1'b0, w_bkt_lo} + {1'b0, w_iv_eff} - (SAMPLE_W+1)'(1);
        if (r_relative) begin
            w_join = (w_rel_hi >= {1'b0, r_sample}) &&
                     ({1'b0, w_rdata.value} <= w_rel_lo_s);
        end else begin
            w_join = (w_rdata.value >= w_bkt_lo) &&
                     ({1'b0, w_rdata.value} <= w_bkt_hi);
        end
    end

    assign w_fl_last   = (TW'(r_k) + TW'(1)) == r_total;
    assign w_new_total = (!r_join && (r_total < TW'(RUN_DEPTH))) ?
                         r_total + TW'(1) : r_total;

    // store accesses. A write lands in S_UPD and the earliest read after it
    // is issued in S_FLUSH_RD or a later state, so no forwarding is needed.
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_total[AW-1:0];
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_k;
        w_rem_start = 1'b0;
        case (r_state)
            S_FLUSH_RD: begin
                w_re    = (r_total != '0);
                w_raddr = r_k;
            end
            S_PREP: begin
                w_re        = (r_total != '0);
                w_raddr     = w_last_idx[AW-1:0];
                w_rem_start = !r_relative;
            end
            S_UPD: begin
                if (r_join) begin
                    w_we          = 1'b1;
                    w_waddr       = w_last_idx[AW-1:0];
                    w_wdata.value = w_rdata.value;
                    w_wdata.count = (w_rdata.count == COUNT_MAX) ?
                                    w_rdata.count : w_rdata.count + COUNT_W'(1);
                end else if (r_total < TW'(RUN_DEPTH)) begin
                    w_we          = 1'b1;
                    w_waddr       = r_total[AW-1:0];
                    w_wdata.value = r_sample;
                    w_wdata.count = COUNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= RST_INTERVAL;
            r_relative <= 1'b0;
            r_max_runs <= RST_MAX_RUNS;
            r_alive    <= RST_ALIVE_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_INTERVAL:   r_interval <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_RELATIVE:   r_relative <= i_cfg_wdata[0];
                CFG_MAX_RUNS:   r_max_runs <= i_cfg_wdata[MAXRUNS_W-1:0];
                CFG_ALIVE_TIME: r_alive    <= i_cfg_wdata[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_sample <= i_s_tdata[SAMPLE_W-1:0];
            r_now    <= i_s_tdata[SAMPLE_W +: TIME_W];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_flush_time <= '0;
            r_k          <= '0;
            r_post       <= 1'b0;
            r_join       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // flush on age before the sample is placed
                    r_k    <= '0;
                    r_post <= 1'b0;
                    if (w_elapsed > r_alive) begin
                        r_state <= S_FLUSH_RD;
                    end else begin
                        r_state <= S_PREP;
                    end
                end
                S_FLUSH_RD: begin
                    if (r_total != '0) begin
                        r_state <= S_FLUSH_WR;
                    end else if (w_slot_free) begin
                        // empty store: emit a single zero pair
                        r_out_valid      <= 1'b1;
                        r_out_data       <= '0;
                        r_out_last       <= 1'b1;
                        r_total          <= '0;
                        r_flush_time     <= r_now;
                        r_state          <= r_post ? S_IDLE : S_PREP;
                    end
                end
                S_FLUSH_WR: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_rdata;
                        r_out_last  <= w_fl_last;
                        if (w_fl_last) begin
                            r_total      <= '0;
                            r_flush_time <= r_now;
                            r_state      <= r_post ? S_IDLE : S_PREP;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_FLUSH_RD;
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_relative || w_rem_stat.done) begin
                        r_state <= S_JOIN;
                    end
                end
                S_JOIN: begin
                    r_join  <= (r_total != '0) && w_join;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_total <= w_new_total;
                    if (CW'(w_new_total) >= w_lim) begin
                        r_k     <= '0;
                        r_post  <= 1'b1;
                        r_state <= S_FLUSH_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the store never holds a full set of runs between words
    a_idle_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_total < TW'(RUN_DEPTH)))
        else $error("run total at depth while idle");

    // loading the final word of a flush empties the store
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH_WR) && w_slot_free && w_fl_last) |=> (r_total == '0))
        else $error("store not cleared after flush");

    // the remainder unit only runs and finishes while the sequencer waits on it
    a_rem_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rem_stat.busy || w_rem_stat.done) |-> (r_state == S_DIV))
        else $error("remainder active outside its wait state");

    // a result is never overwritten while it waits
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("pending result lost");

endmodule

@@ design/trle_store.sv @@
`timescale 1ns / 1ps
// ============================================================================
// trle_store : run store memory
// One write port and one read port, read data registered.
// ============================================================================
module trle_store #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  trle_pkg::t_run_entry  i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output trle_pkg::t_run_entry  o_rdata
);
    import trle_pkg::*;

    t_run_entry r_mem [DEPTH];
    t_run_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/trle_rem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// trle_rem : iterative remainder unit
// Restoring division, one quotient bit a cycle; only the remainder is kept.
// ============================================================================
module trle_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [trle_pkg::SAMPLE_W-1:0] i_dividend,
    input  logic [trle_pkg::SAMPLE_W-1:0] i_divisor,
    output logic [trle_pkg::SAMPLE_W-1:0] o_rem,
    output trle_pkg::t_rem_stat           o_stat
);
    import trle_pkg::*;

    logic [SAMPLE_W-1:0] r_rem, n_rem;
    logic [SAMPLE_W-1:0] r_shf;
    logic [SAMPLE_W-1:0] r_div;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SAMPLE_W:0]   w_trial;
    logic [SAMPLE_W:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_shf[SAMPLE_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[SAMPLE_W-1:0];
        end else begin
            n_rem = w_trial[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(REM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_shf <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_shf <= {r_shf[SAMPLE_W-2:0], 1'b0};
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ dv/tb_tolerant_run_length_encoder_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_tolerant_run_length_encoder_core : self-checking bench for the lossy RLE
// Streams sensor words through the encoder under several register settings.
// A predictor built into the bench computes the flushed runs of each word.
// Every result word is compared field by field with the oldest expected run.
// Both stream sides idle in random bursts.
// ============================================================================
module tb_tolerant_run_length_encoder_core;
    import trle_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WATCH_MAX  = 3000;  // cycles without any handshake
    localparam int SETTLE_CYC = 30;    // covers the slowest no-flush word, a bucket-mode one

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
    } t_sensor_word;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_run_word;

    // ------------------------------------------------------------------------
    // DUT ports; the inputs are all known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [31:0]       o_m_tdata;
    logic              o_m_tlast;
    logic              i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr  = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;

    tolerant_run_length_encoder_core #(
        .RUN_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_sensor_word words_pending[$];   // filled by the sequence, drained by the driver
    t_run_word    runs_due[$];        // flushed runs still to be seen on the output
    int           faults = 0;

    bit src_gaps    = 1'b1;   // allow idle bursts on the slave side
    bit sink_stalls = 1'b1;   // allow stall bursts on the master side
    bit calm        = 1'b0;   // last part of the run: no idling at all

    // predictor copy of the registers and of the run store
    logic [SAMPLE_W-1:0]  cfg_interval;
    logic                 cfg_relative;
    logic [MAXRUNS_W-1:0] cfg_max_runs;
    logic [TIME_W-1:0]    cfg_alive;
    logic [SAMPLE_W-1:0]  run_val [DEPTH];
    logic [COUNT_W-1:0]   run_cnt [DEPTH];
    int                   runs_held;
    logic [TIME_W-1:0]    last_flush;

    // ------------------------------------------------------------------------
    // Predictor: emit the whole store (or one empty marker) and restamp
    // ------------------------------------------------------------------------
    task automatic emit_runs(input logic [TIME_W-1:0] now);
        t_run_word r;
        if (runs_held == 0) begin
            r.value = '0;
            r.count = '0;
            r.last  = 1'b1;
            runs_due.push_back(r);
        end else begin
            for (int k = 0; k < runs_held; k++) begin
                r.value = run_val[k];
                r.count = run_cnt[k];
                r.last  = (k == runs_held - 1);
                runs_due.push_back(r);
            end
        end
        runs_held  = 0;
        last_flush = now;
    endtask

    // Predictor: age check, then join or open a run, then the count check
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] now);
        int          lim;
        logic [31:0] age;
        logic [31:0] rv;
        logic [31:0] iv;
        logic        fits;
        lim = int'(cfg_max_runs);
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        age = now - last_flush;
        if (age > cfg_alive) emit_runs(now);

        fits = 1'b0;
        if (runs_held != 0) begin
            rv = 32'(run_val[runs_held-1]);
            iv = 32'(cfg_interval);
            if (cfg_relative) begin
                // tolerance band around the opening value, no wrap at either end
                fits = (rv + iv >= 32'(s)) && (rv <= 32'(s) + iv);
            end else begin
                if (iv == 0) iv = 32'd1;
                fits = (rv / iv) == (32'(s) / iv);
            end
        end

        if (fits) begin
            // hold the count at its ceiling while samples keep joining
            if (run_cnt[runs_held-1] != COUNT_MAX) run_cnt[runs_held-1]++;
        end else if (runs_held < DEPTH) begin
            run_val[runs_held] = s;
            run_cnt[runs_held] = COUNT_W'(1);
            runs_held++;
        end

        if (runs_held >= lim) emit_runs(now);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present the next pending word, with random idle bursts
    // ------------------------------------------------------------------------
    int           src_hold = 0;
    t_sensor_word next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (src_hold != 0) begin
                src_hold--;
                i_s_tvalid <= 1'b0;
            end else if (words_pending.size() == 0) begin
                i_s_tvalid <= 1'b0;
            end else if (src_gaps && !calm && $urandom_range(0, 5) == 0) begin
                // start an idle burst; src_hold sets its random length
                src_hold = $urandom_range(0, 12);
                i_s_tvalid <= 1'b0;
            end else begin
                next_word = words_pending.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {next_word.now_ms, next_word.sample};
            end
        end
    end

    // Receiver: stall in random bursts
    int sink_hold = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_hold != 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if (sink_stalls && !calm && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(0, 12);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: track register writes, predict accepted words, check results
    // ------------------------------------------------------------------------
    t_run_word due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_interval = RST_INTERVAL;
            cfg_relative = 1'b0;
            cfg_max_runs = RST_MAX_RUNS;
            cfg_alive    = RST_ALIVE_TIME;
            runs_held    = 0;
            last_flush   = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_INTERVAL:   cfg_interval = i_cfg_wdata[SAMPLE_W-1:0];
                    CFG_RELATIVE:   cfg_relative = i_cfg_wdata[0];
                    CFG_MAX_RUNS:   cfg_max_runs = i_cfg_wdata[MAXRUNS_W-1:0];
                    CFG_ALIVE_TIME: cfg_alive    = i_cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end

            // predict first so a same-edge result always finds its entry
            if (i_s_tvalid && o_s_tready)
                absorb_sample(i_s_tdata[15:0], i_s_tdata[47:16]);

            if (o_m_tvalid && i_m_tready) begin
                if (runs_due.size() == 0) begin
                    faults++;
                    $display("%0t unexpected word: expected none, actual %h last %b",
                             $time, o_m_tdata, o_m_tlast);
                end else begin
                    due = runs_due.pop_front();
                    if (o_m_tdata[15:0] !== due.value) begin
                        faults++;
                        $display("%0t run_value: expected %h, actual %h",
                                 $time, due.value, o_m_tdata[15:0]);
                    end
                    if (o_m_tdata[31:16] !== due.count) begin
                        faults++;
                        $display("%0t run_count: expected %h, actual %h",
                                 $time, due.count, o_m_tdata[31:16]);
                    end
                    if (o_m_tlast !== due.last) begin
                        faults++;
                        $display("%0t last: expected %b, actual %b",
                                 $time, due.last, o_m_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we
            || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCH_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every word taken and every run seen, then let the last word finish
    task automatic settle();
        do @(negedge i_clk);
        while (words_pending.size() != 0 || i_s_tvalid || runs_due.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic add_word(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        t_sensor_word w;
        w.sample = s;
        w.now_ms = t;
        words_pending.push_back(w);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0]   stamp;
        logic [SAMPLE_W-1:0] ival;
        logic [SAMPLE_W-1:0] base;
        logic [MAXRUNS_W-1:0] mruns;
        logic [TIME_W-1:0]   alive;
        int                  span;
        int                  v;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: bucket of one, sixteen runs, no age flush; time extremes
        add_word(16'h0000, 32'h0000_0000);
        add_word(16'h0000, 32'h0000_0000);
        add_word(16'h0001, 32'h0000_0001);
        add_word(16'hFFFF, 32'hFFFF_FFFF);
        add_word(16'hFFFF, 32'h8000_0000);
        add_word(16'h8000, 32'h0000_0005);

        // zero interval in bucket mode, two runs per flush, short alive time
        settle();
        write_reg(CFG_INTERVAL, 32'h0000_0000);
        write_reg(CFG_MAX_RUNS, 32'd2);
        write_reg(CFG_ALIVE_TIME, 32'd100);
        end_writes();
        add_word(16'd5, 32'd200);    // age flush of the four stored runs
        add_word(16'd5, 32'd210);    // equal value joins
        add_word(16'd6, 32'd220);    // second run, count flush
        add_word(16'd7, 32'd400);    // age flush of an empty store

        // relative mode, zero tolerance, limit below range clamps to one run
        settle();
        write_reg(CFG_RELATIVE, 32'h0000_0001);
        write_reg(CFG_MAX_RUNS, 32'd0);
        write_reg(CFG_ALIVE_TIME, 32'd0);
        end_writes();
        add_word(16'd7, 32'd400);
        add_word(16'd7, 32'd401);
        add_word(16'hFFFF, 32'd401);

        // tolerance of three, limit above range, junk in the unused write bits
        settle();
        write_reg(CFG_INTERVAL, 32'hABCD_0003);
        write_reg(CFG_MAX_RUNS, 32'hFFFF_FFFF);   // 31, clamps to the store depth
        write_reg(CFG_ALIVE_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_RELATIVE, 32'h5A5A_5A5B);
        end_writes();
        add_word(16'd100, 32'd1);
        add_word(16'd103, 32'd2);
        add_word(16'd97,  32'd3);
        add_word(16'd104, 32'd4);
        add_word(16'd0,   32'd5);
        add_word(16'd3,   32'd6);
        add_word(16'hFFFF, 32'd7);   // no wrap back to zero
        add_word(16'hFFFC, 32'd8);

        // widest tolerance: every sample joins the last run
        settle();
        src_gaps = 1'b0;
        write_reg(CFG_INTERVAL, 32'h0000_FFFF);
        end_writes();
        for (int n = 0; n < 20; n++)
            add_word(16'($urandom_range(0, 65535)), $urandom);
        settle();
        write_reg(CFG_ALIVE_TIME, 32'd0);
        end_writes();
        add_word(16'd42, 32'h1234_5678);   // age flush shows the accumulated count

        // random phases: new settings each time, mostly runs of nearby samples
        stamp = 32'h1234_5678;
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            if (ph == 7) calm = 1'b1;
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 4))
                0:       ival = 16'd0;
                1:       ival = 16'd1;
                2:       ival = 16'($urandom_range(2, 8));
                3:       ival = 16'hFFFF;
                default: ival = 16'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       mruns = 5'd0;
                1:       mruns = 5'd1;
                2:       mruns = 5'd2;
                3:       mruns = 5'd16;
                4:       mruns = 5'($urandom_range(17, 31));
                default: mruns = 5'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       alive = 32'd0;
                1:       alive = $urandom_range(1, 50);
                2:       alive = 32'hFFFF_FFFF;
                default: alive = $urandom;
            endcase

            write_reg(CFG_INTERVAL, {16'($urandom), ival});
            write_reg(CFG_RELATIVE, {31'($urandom), 1'($urandom_range(0, 1))});
            write_reg(CFG_MAX_RUNS, {27'($urandom), mruns});
            write_reg(CFG_ALIVE_TIME, alive);
            end_writes();

            span = (ival > 300) ? 301 : int'(ival) + 1;
            base = 16'($urandom_range(0, 65535));
            for (int n = 0; n < 45; n++) begin
                // advance time mostly in small steps, sometimes far enough to wrap
                case ($urandom_range(0, 9))
                    0:       stamp = $urandom;
                    1, 2:    stamp = stamp + $urandom_range(0, 1000);
                    default: stamp = stamp + $urandom_range(0, 40);
                endcase

                if ($urandom_range(0, 9) == 0) begin
                    // noise word
                    add_word(16'($urandom_range(0, 65535)), stamp);
                end else begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 5))
                            0:       base = 16'h0000;
                            1:       base = 16'hFFFF;
                            default: base = 16'($urandom_range(0, 65535));
                        endcase
                    end
                    v = int'(base) + $urandom_range(0, 2 * span) - span;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                    add_word(16'(v), stamp);
                end
            end
        end

        // drain, then give any stray word time to show up
        do @(negedge i_clk);
        while (words_pending.size() != 0 || i_s_tvalid || runs_due.size() != 0);
        repeat (40) @(posedge i_clk);

        if (faults == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
